>>> sv/decttf_pkg.sv
// decttf_pkg: widths, character codes and shared types of the decimal text parser
// no dependencies; imported by every other file of the block
`default_nettype none

package decttf_pkg;

    localparam int CHAR_W          = 8;
    localparam int VALUE_W         = 64;
    localparam int MANT_W          = 60;
    localparam int PROD_W          = 64;
    localparam int WORK_W          = 128;
    localparam int DIGIT_W         = 4;
    localparam int FCNT_W          = 6;
    localparam int DOWN_W          = 6;
    localparam int DIV_CAP         = 37;
    localparam int FRAC_BITS_DEF   = 24;
    localparam int MANT_DIGITS_DEF = 18;

    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOW_E = 8'h65;
    localparam logic [CHAR_W-1:0] CH_UP_E  = 8'h45;

    typedef struct packed {
        logic               add;
        logic [DIGIT_W-1:0] digit;
    } digit_req_t;

    typedef struct packed {
        logic               negative;
        logic [DIGIT_W-1:0] up;
        logic [DOWN_W-1:0]  down;
    } scale_req_t;

    function automatic logic [PROD_W-1:0] mant_limit(input int digits);
        logic [PROD_W-1:0] p;
        p = 64'd1;
        for (int i = 0; i < digits; i++)
        begin
            p = p * 64'd10;
        end
        return p - 64'd1;
    endfunction

endpackage

`default_nettype wire

>>> sv/decttf_if.sv
// decttf_char_if / decttf_res_if: valid-ready channels of the parser
// depends on decttf_pkg for payload widths
`default_nettype none

interface decttf_char_if import decttf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] char_code;
    logic              last;

    modport source (output valid, output char_code, output last, input ready);
    modport sink   (input valid, input char_code, input last, output ready);
endinterface

interface decttf_res_if import decttf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      overflow;

    modport source (output valid, output value, output overflow, input ready);
    modport sink   (input valid, input value, input overflow, output ready);
endinterface

`default_nettype wire

>>> sv/decimal_text_to_fixed_parser.sv
// decimal_text_to_fixed_parser: top level of the decimal text to fixed point parser
// depends on decttf_pkg, decttf_if, decttf_grammar, decttf_datapath
//
//   port    dir  payload                      role
//   chars   in   char_code[7:0], last         one character per request
//   result  out  value[63:0] signed, overflow one result per string, after last
//
// a non-digit character is taken in the idle state; a digit takes a times-ten add, then
// a limit check; a last character adds the load, up steps on the shared times-ten unit,
// min(down, 37) byte-serial divides by ten and the final stage, up being the positive
// exponent digit and down the fraction digits plus a negative exponent digit
// rst_n clears the parser to its whitespace state; the result register holds a result
// under stall while characters of the next string are still taken, and the final
// stage waits while that result is still unaccepted
`default_nettype none

module decimal_text_to_fixed_parser import decttf_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int MANT_DIGITS = MANT_DIGITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    decttf_char_if.sink   chars,
    decttf_res_if.source  result
);

    logic       fire;
    logic       ready;
    digit_req_t dig_req;
    scale_req_t scale_req;

    assign fire        = chars.valid && ready;
    assign chars.ready = ready;

    decttf_grammar u_grammar
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .char_code (chars.char_code),
        .last      (chars.last),
        .dig_req   (dig_req),
        .scale_req (scale_req)
    );

    decttf_datapath #(
        .FRAC_BITS   (FRAC_BITS),
        .MANT_DIGITS (MANT_DIGITS)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_fire      (fire),
        .in_last      (chars.last),
        .dig_req      (dig_req),
        .scale_req    (scale_req),
        .in_ready     (ready),
        .res_valid    (result.valid),
        .res_ready    (result.ready),
        .res_value    (result.value),
        .res_overflow (result.overflow)
    );

endmodule

`default_nettype wire

>>> sv/decttf_mul10.sv
// decttf_mul10: shared times-ten-plus-digit unit of the parser
// depends on decttf_pkg
`default_nettype none

module decttf_mul10 import decttf_pkg::*;
(
    input  logic [WORK_W-1:0]  x,
    input  logic [DIGIT_W-1:0] d,
    output logic [WORK_W-1:0]  y
);

    assign y = (x << 3) + (x << 1) + {{(WORK_W-DIGIT_W){1'b0}}, d};

endmodule

`default_nettype wire

>>> sv/decttf_grammar.sv
// decttf_grammar: character classes and grammar state machine of the parser
// depends on decttf_pkg; feeds digit and scaling requests to decttf_datapath
`default_nettype none

module decttf_grammar import decttf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              last,
    output digit_req_t        dig_req,
    output scale_req_t        scale_req
);

    typedef enum logic [5:0] {
        P_SPACE  = 6'b000001,
        P_INT    = 6'b000010,
        P_FRAC   = 6'b000100,
        P_ESIGN  = 6'b001000,
        P_EDIGIT = 6'b010000,
        P_DONE   = 6'b100000
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic               neg_reg, neg_next;
    logic [FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic               eneg_reg, eneg_next;
    logic [DIGIT_W-1:0] edig_reg, edig_next;

    logic               is_dig;
    logic               is_e;
    logic               is_ws;
    logic [DIGIT_W-1:0] dval;
    logic               add;
    logic [DOWN_W:0]    down_raw;

    assign is_dig = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_e   = (char_code == CH_LOW_E) || (char_code == CH_UP_E);
    assign is_ws  = ((char_code >= CH_TAB) && (char_code <= CH_CR)) || (char_code == CH_SPACE);
    assign dval   = is_dig ? DIGIT_W'(char_code - CH_ZERO) : '0;

    always_comb
    begin
        phase_next = phase_reg;
        neg_next   = neg_reg;
        fcnt_next  = fcnt_reg;
        eneg_next  = eneg_reg;
        edig_next  = edig_reg;
        add        = 1'b0;
        unique case (phase_reg)
            P_SPACE:
            begin
                priority if (is_ws)
                begin
                    phase_next = P_SPACE;
                end
                else if (char_code == CH_MINUS)
                begin
                    neg_next   = 1'b1;
                    phase_next = P_INT;
                end
                else if (char_code == CH_PLUS)
                begin
                    phase_next = P_INT;
                end
                else if (is_dig)
                begin
                    add        = 1'b1;
                    phase_next = P_INT;
                end
                else if (char_code == CH_DOT)
                begin
                    phase_next = P_FRAC;
                end
                else if (is_e)
                begin
                    phase_next = P_ESIGN;
                end
                else
                begin
                    phase_next = P_DONE;
                end
            end
            P_INT:
            begin
                priority if (is_dig)
                begin
                    add = 1'b1;
                end
                else if (char_code == CH_DOT)
                begin
                    phase_next = P_FRAC;
                end
                else if (is_e)
                begin
                    phase_next = P_ESIGN;
                end
                else
                begin
                    phase_next = P_DONE;
                end
            end
            P_FRAC:
            begin
                priority if (is_dig)
                begin
                    add = 1'b1;
                    if (fcnt_reg != {FCNT_W{1'b1}})
                    begin
                        fcnt_next = fcnt_reg + 1'b1;
                    end
                end
                else if (is_e)
                begin
                    phase_next = P_ESIGN;
                end
                else
                begin
                    phase_next = P_DONE;
                end
            end
            P_ESIGN:
            begin
                priority if (char_code == CH_MINUS)
                begin
                    eneg_next  = 1'b1;
                    phase_next = P_EDIGIT;
                end
                else if (is_dig)
                begin
                    edig_next  = dval;
                    phase_next = P_DONE;
                end
                else
                begin
                    phase_next = P_DONE;
                end
            end
            P_EDIGIT:
            begin
                if (is_dig)
                begin
                    edig_next = dval;
                end
                phase_next = P_DONE;
            end
            P_DONE:
            begin
                phase_next = P_DONE;
            end
            default:
            begin
                phase_next = P_DONE;
            end
        endcase
    end

    assign dig_req.add   = add;
    assign dig_req.digit = dval;

    // scaling exponents as seen after this character
    assign down_raw = {1'b0, fcnt_next} + {3'b000, (eneg_next ? edig_next : {DIGIT_W{1'b0}})};
    assign scale_req.negative = neg_next;
    assign scale_req.up       = eneg_next ? '0 : edig_next;
    assign scale_req.down     = (down_raw > (DOWN_W+1)'(DIV_CAP)) ? DOWN_W'(DIV_CAP)
                                                                  : down_raw[DOWN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= P_SPACE;
            neg_reg   <= 1'b0;
            fcnt_reg  <= '0;
            eneg_reg  <= 1'b0;
            edig_reg  <= '0;
        end
        else if (fire)
        begin
            if (last)
            begin
                phase_reg <= P_SPACE;
                neg_reg   <= 1'b0;
                fcnt_reg  <= '0;
                eneg_reg  <= 1'b0;
                edig_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                fcnt_reg  <= fcnt_next;
                eneg_reg  <= eneg_next;
                edig_reg  <= edig_next;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/decttf_datapath.sv
// decttf_datapath: mantissa register, scaling sequencer and result register
// depends on decttf_pkg and decttf_mul10
`default_nettype none

module decttf_datapath import decttf_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int MANT_DIGITS = MANT_DIGITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_fire,
    input  logic                      in_last,
    input  digit_req_t                dig_req,
    input  scale_req_t                scale_req,
    output logic                      in_ready,
    output logic                      res_valid,
    input  logic                      res_ready,
    output logic signed [VALUE_W-1:0] res_value,
    output logic                      res_overflow
);

    localparam logic [PROD_W-1:0] MANT_LIM = mant_limit(MANT_DIGITS);
    localparam int NBYTES = WORK_W / 8;
    localparam int BCNT_W = $clog2(NBYTES);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ACC  = 6'b000010,
        S_LOAD = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_SAT  = 6'b100000
    } dp_state_t;

    dp_state_t          state_reg, state_next;
    logic [WORK_W-1:0]  w_reg, w_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic               sat_reg, sat_next;
    logic               pend_reg, pend_next;
    scale_req_t         scale_reg, scale_next;
    logic [DIGIT_W-1:0] up_reg, up_next;
    logic [DOWN_W-1:0]  div_reg, div_next;
    logic [BCNT_W-1:0]  byte_reg, byte_next;
    logic [3:0]         rem_reg, rem_next;

    logic                      rv_reg, rv_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic                      ovf_reg, ovf_next;

    logic [DIGIT_W-1:0] mul_d;
    logic [WORK_W-1:0]  mul_y;
    logic [11:0]        div_out;
    logic               big;
    logic [VALUE_W-1:0] mag;

    function automatic logic [11:0] div10_byte(input logic [3:0] rem_in,
                                               input logic [7:0] bits_in);
        logic [4:0] r;
        logic [7:0] q;
        r = {1'b0, rem_in};
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            r = {r[3:0], bits_in[i]};
            if (r >= 5'd10)
            begin
                r    = r - 5'd10;
                q[i] = 1'b1;
            end
        end
        return {r[3:0], q};
    endfunction

    assign mul_d = (state_reg == S_IDLE) ? dig_req.digit : '0;

    decttf_mul10 u_mul10
    (
        .x (w_reg),
        .d (mul_d),
        .y (mul_y)
    );

    assign div_out = div10_byte(rem_reg, w_reg[WORK_W-1 -: 8]);
    assign mag     = w_reg[VALUE_W-1:0];
    assign big     = (w_reg[WORK_W-1:VALUE_W] != '0) ||
                     (w_reg[VALUE_W-1] &&
                      ((w_reg[VALUE_W-2:0] != '0) || !scale_reg.negative));

    always_comb
    begin
        state_next = state_reg;
        w_next     = w_reg;
        prod_next  = prod_reg;
        sat_next   = sat_reg;
        pend_next  = pend_reg;
        scale_next = scale_reg;
        up_next    = up_reg;
        div_next   = div_reg;
        byte_next  = byte_reg;
        rem_next   = rem_reg;
        rv_next    = rv_reg && !res_ready;
        val_next   = val_reg;
        ovf_next   = ovf_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pend_next = in_last;
                    if (in_last)
                    begin
                        scale_next = scale_req;
                    end
                    if (dig_req.add)
                    begin
                        prod_next  = mul_y[PROD_W-1:0];
                        state_next = S_ACC;
                    end
                    else if (in_last)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_ACC:
            begin
                if (prod_reg > MANT_LIM)
                begin
                    w_next   = {{(WORK_W-PROD_W){1'b0}}, MANT_LIM};
                    sat_next = 1'b1;
                end
                else
                begin
                    w_next = {{(WORK_W-PROD_W){1'b0}}, prod_reg};
                end
                state_next = pend_reg ? S_LOAD : S_IDLE;
            end
            S_LOAD:
            begin
                w_next     = w_reg << FRAC_BITS;
                up_next    = scale_reg.up;
                div_next   = scale_reg.down;
                byte_next  = '0;
                rem_next   = '0;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (up_reg == '0)
                begin
                    state_next = S_DIV;
                end
                else
                begin
                    w_next  = mul_y;
                    up_next = up_reg - 1'b1;
                end
            end
            S_DIV:
            begin
                if (div_reg == '0)
                begin
                    state_next = S_SAT;
                end
                else
                begin
                    w_next    = {w_reg[WORK_W-9:0], div_out[7:0]};
                    byte_next = byte_reg + 1'b1;
                    if (byte_reg == {BCNT_W{1'b1}})
                    begin
                        div_next = div_reg - 1'b1;
                        rem_next = '0;
                    end
                    else
                    begin
                        rem_next = div_out[11:8];
                    end
                end
            end
            S_SAT:
            begin
                if (!rv_reg || res_ready)
                begin
                    rv_next  = 1'b1;
                    ovf_next = big || sat_reg;
                    if (big)
                    begin
                        val_next = scale_reg.negative ? {1'b1, {(VALUE_W-1){1'b0}}}
                                                      : {1'b0, {(VALUE_W-1){1'b1}}};
                    end
                    else
                    begin
                        val_next = scale_reg.negative ? -mag : mag;
                    end
                    w_next     = '0;
                    sat_next   = 1'b0;
                    pend_next  = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            w_reg     <= '0;
            sat_reg   <= 1'b0;
            pend_reg  <= 1'b0;
            up_reg    <= '0;
            div_reg   <= '0;
            byte_reg  <= '0;
            rem_reg   <= '0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            w_reg     <= w_next;
            sat_reg   <= sat_next;
            pend_reg  <= pend_next;
            up_reg    <= up_next;
            div_reg   <= div_next;
            byte_reg  <= byte_next;
            rem_reg   <= rem_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        scale_reg <= scale_next;
        val_reg   <= val_next;
        ovf_reg   <= ovf_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign res_valid    = rv_reg;
    assign res_value    = val_reg;
    assign res_overflow = ovf_reg;

    a_acc_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ACC |-> $past(in_fire))
        else $error("digit check without a preceding request");

    a_idle_mant_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> w_reg <= {{(WORK_W-PROD_W){1'b0}}, MANT_LIM})
        else $error("mantissa above limit while idle");

    a_result_from_sat: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rv_reg) |-> $past(state_reg == S_SAT))
        else $error("result raised outside final stage");

    a_div_boundary: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_reg == '0) |-> byte_reg == '0 && rem_reg == '0)
        else $error("division finished mid-word");

endmodule

`default_nettype wire
